// File: rtl/core/boundary_line_escape_fsm_assert.svh
// Assertion macros for the boundary-line escape controller.
`ifndef BOUNDARY_LINE_ESCAPE_FSM_ASSERT_SVH
`define BOUNDARY_LINE_ESCAPE_FSM_ASSERT_SVH

// Checked on the rising edge, muted while in reset.
`define BLEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from a qualifying condition to a consequence in the same cycle.
`define BLEF_ASSERT_IMPL(lbl, cond, cons, msg) \
  `BLEF_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// File: rtl/core/blef_pkg.sv
// Types and constants of the boundary-line escape controller.
package blef_pkg;

  localparam int unsigned AngleW = 12;
  localparam int unsigned GapW   = 11;
  localparam int unsigned WidthW = 9;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned LocW   = 2;

  localparam logic [AngleW-1:0] FullTurn = AngleW'(3600);
  localparam logic [AngleW-1:0] HalfTurn = AngleW'(1800);
  localparam logic [WidthW-1:0] OneQ8    = WidthW'(256);

  localparam logic [GapW-1:0]   ExitLimitRst   = GapW'(1200);
  localparam logic [GapW-1:0]   ReturnLimitRst = GapW'(800);
  localparam logic [SpeedW-1:0] FullOutRst     = SpeedW'(768);

  typedef enum logic [1:0] {
    CFG_EXIT_LIMIT   = 2'd0,
    CFG_RETURN_LIMIT = 2'd1,
    CFG_FULL_OUT     = 2'd2
  } cfg_idx_e;

  // Location codes as seen on the result word.
  localparam logic [LocW-1:0] LOC_CODE_INSIDE = 2'd0;
  localparam logic [LocW-1:0] LOC_CODE_ON     = 2'd1;
  localparam logic [LocW-1:0] LOC_CODE_OUT    = 2'd2;

  typedef enum logic [2:0] {
    LOC_INSIDE = 3'b001,
    LOC_ON     = 3'b010,
    LOC_OUT    = 3'b100
  } loc_e;

  typedef struct packed {
    logic              line_seen;
    logic [AngleW-1:0] line_angle;
    logic [WidthW-1:0] line_width;
  } item_t;

  typedef struct packed {
    logic              move_valid;
    logic [AngleW-1:0] move_direction;
    logic [SpeedW-1:0] move_speed;
    logic [LocW-1:0]   location;
  } result_t;

  typedef struct packed {
    logic [1:0]      reg_index;
    logic [GapW-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [GapW-1:0]   exit_limit;
    logic [GapW-1:0]   return_limit;
    logic [SpeedW-1:0] full_out_speed;
  } cfg_regs_t;

  function automatic logic [LocW-1:0] loc_code(loc_e loc);
    logic [LocW-1:0] code;
    case (loc)
      LOC_ON:  code = LOC_CODE_ON;
      LOC_OUT: code = LOC_CODE_OUT;
      default: code = LOC_CODE_INSIDE;
    endcase
    return code;
  endfunction

  // Wrapped distance between two reduced angles, 0..1800.
  function automatic logic [GapW-1:0] angle_gap(logic [AngleW-1:0] a, logic [AngleW-1:0] b);
    logic [AngleW-1:0] d;
    logic [AngleW-1:0] w;
    d = (a >= b) ? (a - b) : (b - a);
    w = (d > HalfTurn) ? (FullTurn - d) : d;
    return w[GapW-1:0];
  endfunction

endpackage

// File: rtl/core/blef_if.sv
// Valid/ready channel carrying one word of type T.
interface blef_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/boundary_line_escape_fsm.sv
// Boundary-line escape controller: one sighting word in, one move word out.
// Each sighting word passes an input register and then the decision logic into the
// result register, from which its result is offered; a new word is taken every
// cycle while the result side keeps up. The location state and the first and last
// angles are updated as each word leaves the input register, which sets the
// one-word-per-cycle rate. Configuration writes are taken every cycle.
module boundary_line_escape_fsm (
  input logic  clk_i,
  input logic  rst_ni,
  blef_if.sink   item_i,
  blef_if.source result_o,
  blef_if.sink   cfg_i
);
  import blef_pkg::*;

  cfg_regs_t regs;
  logic      stage_valid;
  item_t     stage_item;
  logic      take;

  blef_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  blef_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  blef_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .regs_i   (regs),
    .valid_i  (stage_valid),
    .item_i   (stage_item),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule

// File: rtl/core/blef_cfg_regs.sv
// Configuration registers: angle limits and full-out speed.
module blef_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  blef_if.sink                cfg_i,
  output blef_pkg::cfg_regs_t regs_o
);
  import blef_pkg::*;

  cfg_regs_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.exit_limit     <= ExitLimitRst;
      regs_q.return_limit   <= ReturnLimitRst;
      regs_q.full_out_speed <= FullOutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.reg_index)
        CFG_EXIT_LIMIT:   regs_q.exit_limit     <= cfg_i.data.wdata;
        CFG_RETURN_LIMIT: regs_q.return_limit   <= cfg_i.data.wdata;
        CFG_FULL_OUT:     regs_q.full_out_speed <= cfg_i.data.wdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/blef_in_stage.sv
// Input register for sighting words.
module blef_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  blef_if.sink            item_i,
  input  logic            take_i,
  output logic            valid_o,
  output blef_pkg::item_t item_o
);
  import blef_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign item_i.ready = !valid_q || take_i;
  assign valid_o      = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= item_i.data;
    end
  end

endmodule

// File: rtl/core/blef_core.sv
// Location state, move decision and result register.
module blef_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blef_pkg::cfg_regs_t regs_i,
  input  logic                valid_i,
  input  blef_pkg::item_t     item_i,
  output logic                take_o,
  blef_if.source              result_o
);
  import blef_pkg::*;

  loc_e              loc_q, loc_d;
  logic [AngleW-1:0] first_q, first_d;
  logic [AngleW-1:0] last_q, last_d;
  logic              out_valid_q;
  result_t           out_q, out_d;

  logic [AngleW-1:0] ang;
  logic [AngleW:0]   opp_sum;
  logic [AngleW-1:0] opp;
  logic [SpeedW-1:0] spd_up;
  logic [SpeedW-1:0] spd_down;
  logic [GapW-1:0]   gap;

  assign take_o = valid_i && (!out_valid_q || result_o.ready);

  always_comb begin
    ang      = (item_i.line_angle >= FullTurn) ? (item_i.line_angle - FullTurn)
                                               : item_i.line_angle;
    opp_sum  = {1'b0, ang} + {1'b0, HalfTurn};
    opp      = (opp_sum >= {1'b0, FullTurn}) ? AngleW'(opp_sum - {1'b0, FullTurn})
                                             : opp_sum[AngleW-1:0];
    spd_up   = SpeedW'(item_i.line_width) + SpeedW'(OneQ8);
    spd_down = (item_i.line_width >= OneQ8) ? '0
                                            : SpeedW'(OneQ8 - item_i.line_width);

    first_d = (loc_q == LOC_INSIDE && item_i.line_seen) ? ang : first_q;
    last_d  = item_i.line_seen ? ang : last_q;
    gap     = angle_gap(ang, first_d);
    loc_d   = loc_q;

    out_d.move_valid     = 1'b0;
    out_d.move_direction = '0;
    out_d.move_speed     = '0;

    if (loc_q == LOC_OUT) begin
      out_d.move_valid = 1'b1;
      if (!item_i.line_seen) begin
        out_d.move_direction = last_q;
        out_d.move_speed     = regs_i.full_out_speed;
      end else if (gap < regs_i.return_limit) begin
        out_d.move_direction = ang;
        out_d.move_speed     = spd_down;
        loc_d                = LOC_ON;
      end else begin
        out_d.move_direction = ang;
        out_d.move_speed     = spd_up;
      end
    end else if (!item_i.line_seen) begin
      loc_d = LOC_INSIDE;
    end else begin
      out_d.move_valid = 1'b1;
      if (gap >= regs_i.exit_limit) begin
        out_d.move_direction = ang;
        out_d.move_speed     = spd_up;
        loc_d                = LOC_OUT;
      end else begin
        out_d.move_direction = opp;
        out_d.move_speed     = spd_down;
        loc_d                = LOC_ON;
      end
    end

    out_d.location = loc_code(loc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q       <= LOC_INSIDE;
      first_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        loc_q   <= loc_d;
        first_q <= first_d;
        last_q  <= last_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

// File: rtl/core/blef_checker.sv
// Port-level checks of the boundary-line escape controller and their binding.
`include "boundary_line_escape_fsm_assert.svh"

module blef_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input blef_pkg::result_t out_data_i
);
  import blef_pkg::*;

  `BLEF_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result word changed while stalled")
  `BLEF_ASSERT_IMPL(a_no_move_zero, out_valid_i && !out_data_i.move_valid, out_data_i.move_direction == '0 && out_data_i.move_speed == '0, "no-move word carries direction or speed")
  `BLEF_ASSERT_IMPL(a_out_moves, out_valid_i && out_data_i.location == LOC_CODE_OUT, out_data_i.move_valid, "outside without a move")
  `BLEF_ASSERT_IMPL(a_in_still, out_valid_i && out_data_i.location == LOC_CODE_INSIDE, !out_data_i.move_valid, "inside with a move")

endmodule

bind boundary_line_escape_fsm blef_checker u_blef_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);

// File: tb/escape_move_checker.sv
// Predicts the move word for every accepted sighting word and compares it with the block's output.
module escape_move_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic              item_ready_i,
  input  blef_pkg::item_t   item_i,
  input  logic              result_valid_i,
  input  logic              result_ready_i,
  input  blef_pkg::result_t result_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  blef_pkg::cfg_t    cfg_i,
  output int unsigned       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import blef_pkg::*;

  logic [GapW-1:0]   exit_limit   = ExitLimitRst;
  logic [GapW-1:0]   back_limit   = ReturnLimitRst;
  logic [SpeedW-1:0] lost_speed   = FullOutRst;
  logic [LocW-1:0]   where_now    = LOC_CODE_INSIDE;
  logic [AngleW-1:0] first_seen   = '0;
  logic [AngleW-1:0] latest_seen  = '0;
  result_t           expected_moves[$];
  int unsigned       mismatches   = 0;

  function automatic int unsigned wrap_gap(logic [AngleW-1:0] a, logic [AngleW-1:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d < 0) d = -d;
    if (d > int'(HalfTurn)) d = int'(FullTurn) - d;
    return d;
  endfunction

  function automatic result_t predict_move(item_t w);
    result_t           r;
    logic [AngleW-1:0] ang;
    logic [SpeedW-1:0] spd_up;
    logic [SpeedW-1:0] spd_down;
    r = '0;
    ang = w.line_angle;
    if (ang >= FullTurn) ang = ang - FullTurn;
    spd_up   = SpeedW'(w.line_width) + SpeedW'(OneQ8);
    spd_down = (w.line_width >= OneQ8) ? '0 : SpeedW'(OneQ8 - w.line_width);
    if (where_now == LOC_CODE_OUT) begin
      r.move_valid     = 1'b1;
      r.move_direction = ang;
      if (!w.line_seen) begin
        r.move_direction = latest_seen;
        r.move_speed     = lost_speed;
      end else if (wrap_gap(ang, first_seen) < back_limit) begin
        r.move_speed = spd_down;
        where_now    = LOC_CODE_ON;
      end else begin
        r.move_speed = spd_up;
      end
    end else if (!w.line_seen) begin
      where_now = LOC_CODE_INSIDE;
    end else begin
      if (where_now != LOC_CODE_ON) first_seen = ang;
      r.move_valid = 1'b1;
      if (wrap_gap(ang, first_seen) >= exit_limit) begin
        r.move_direction = ang;
        r.move_speed     = spd_up;
        where_now        = LOC_CODE_OUT;
      end else begin
        // head away from the line: opposite direction
        r.move_direction = (ang < HalfTurn) ? ang + HalfTurn : ang - HalfTurn;
        r.move_speed     = spd_down;
        where_now        = LOC_CODE_ON;
      end
    end
    if (w.line_seen) latest_seen = ang;
    r.location = where_now;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      exit_limit  = ExitLimitRst;
      back_limit  = ReturnLimitRst;
      lost_speed  = FullOutRst;
      where_now   = LOC_CODE_INSIDE;
      first_seen  = '0;
      latest_seen = '0;
      expected_moves.delete();
      mismatches  = 0;
      fail_count_o <= 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (expected_moves.size() == 0) begin
          $error("move word with no sighting pending");
          mismatches++;
        end else begin
          want = expected_moves.pop_front();
          if (result_i.move_valid !== want.move_valid) begin
            $error("move_valid: expected %0d, got %0d", want.move_valid, result_i.move_valid);
            mismatches++;
          end
          if (result_i.move_direction !== want.move_direction) begin
            $error("move_direction: expected %0d, got %0d",
                   want.move_direction, result_i.move_direction);
            mismatches++;
          end
          if (result_i.move_speed !== want.move_speed) begin
            $error("move_speed: expected %0d, got %0d", want.move_speed, result_i.move_speed);
            mismatches++;
          end
          if (result_i.location !== want.location) begin
            $error("location: expected %0d, got %0d", want.location, result_i.location);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_i.reg_index)
          CFG_EXIT_LIMIT:   exit_limit = cfg_i.wdata;
          CFG_RETURN_LIMIT: back_limit = cfg_i.wdata;
          CFG_FULL_OUT:     lost_speed = cfg_i.wdata[SpeedW-1:0];
          default: ;
        endcase
      end
      if (item_valid_i && item_ready_i) expected_moves.push_back(predict_move(item_i));
      fail_count_o <= mismatches + expected_moves.size();
    end
  end

endmodule

// File: tb/boundary_line_escape_fsm_tb.sv
// Stimulus, clock, reset and verdict for the boundary-line escape controller.
module boundary_line_escape_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blef_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  int unsigned n_sent       = 0;
  int unsigned n_recv       = 0;
  bit          src_steady   = 1'b0;
  bit          snk_steady   = 1'b0;
  bit          hold_results = 1'b0;
  int          anchor       = 0;
  logic [10:0] exit_now     = 11'(ExitLimitRst);
  logic [10:0] return_now   = 11'(ReturnLimitRst);
  int unsigned fail_count;

  blef_if #(.T(item_t))   item_if ();
  blef_if #(.T(result_t)) result_if ();
  blef_if #(.T(cfg_t))    cfg_if ();

  boundary_line_escape_fsm i_dut (
    .clk_i,
    .rst_ni,
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  escape_move_checker i_move_check (
    .clk_i,
    .rst_ni,
    .item_valid_i   (item_if.valid),
    .item_ready_i   (item_if.ready),
    .item_i         (item_if.data),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .result_i       (result_if.data),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_ready_i    (cfg_if.ready),
    .cfg_i          (cfg_if.data),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("boundary_line_escape_fsm verification failed");
    $finish;
  end

  task automatic put_sighting(input logic seen, input logic [11:0] angle,
                              input logic [8:0] width);
    int unsigned gap;
    item_t       w;
    gap = src_steady ? 0 : $urandom_range(0, 17);
    w = '{line_seen: seen, line_angle: angle, line_width: width};
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= w;
    do @(posedge clk_i); while (!item_if.ready);
    n_sent++;
    if (n_sent % 64 == 0) src_steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic settle();
    item_if.valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [10:0] ex, input logic [10:0] ret,
                           input logic [10:0] spd);
    cfg_t words [4];
    settle();
    words[0] = '{reg_index: CfgSpare, wdata: 11'($urandom_range(0, 2047))};
    words[1] = '{reg_index: CFG_EXIT_LIMIT, wdata: ex};
    words[2] = '{reg_index: CFG_RETURN_LIMIT, wdata: ret};
    words[3] = '{reg_index: CFG_FULL_OUT, wdata: spd};
    foreach (words[k]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= words[k];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    exit_now   = ex;
    return_now = ret;
  endtask

  function automatic logic [10:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 11'd0;
      1:       return 11'd1800;
      2:       return 11'd2047;
      3:       return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(400, 1600));
    endcase
  endfunction

  // Mostly sightings near the first angle and near the thresholds, so that
  // every location and transition is reached repeatedly.
  task automatic random_sighting();
    logic       seen;
    int         a;
    int         off;
    logic [8:0] w;
    seen = ($urandom_range(0, 4) != 0);
    if (!seen) begin
      a = $urandom_range(0, 4095);
      if ($urandom_range(0, 2) == 0) anchor = $urandom_range(0, 3599);
    end else if ($urandom_range(0, 4) == 0) begin
      a = $urandom_range(0, 4095);
    end else begin
      case ($urandom_range(0, 3))
        0:       off = $urandom_range(0, 200);
        1:       off = int'(exit_now) + int'($urandom_range(0, 4)) - 2;
        2:       off = int'(return_now) + int'($urandom_range(0, 4)) - 2;
        default: off = 1800 + int'($urandom_range(0, 6)) - 3;
      endcase
      if ($urandom_range(0, 1) != 0) off = -off;
      a = (anchor + off + 7200) % 3600;
      if (a < 496 && $urandom_range(0, 7) == 0) a = a + 3600;
    end
    case ($urandom_range(0, 3))
      0, 1: w = 9'($urandom_range(0, 256));
      2:    w = 9'($urandom_range(0, 511));
      default: begin
        case ($urandom_range(0, 4))
          0:       w = 9'd0;
          1:       w = 9'd255;
          2:       w = 9'd256;
          3:       w = 9'd257;
          default: w = 9'd511;
        endcase
      end
    endcase
    put_sighting(seen, 12'(a), w);
  endtask

  initial begin
    rst_ni        = 1'b0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: walk through every location
    put_sighting(1'b0, 12'hABC, 9'h1FF);
    put_sighting(1'b1, 12'd0,    9'd0);
    put_sighting(1'b1, 12'd1199, 9'd256);
    put_sighting(1'b1, 12'd1200, 9'd511);
    put_sighting(1'b0, 12'h555,  9'd0);
    put_sighting(1'b1, 12'd2000, 9'd0);
    put_sighting(1'b1, 12'd4095, 9'd100);
    put_sighting(1'b0, 12'd0,    9'd0);
    put_sighting(1'b1, 12'd3599, 9'd300);
    put_sighting(1'b1, 12'd3600, 9'd255);
    put_sighting(1'b1, 12'd1799, 9'd0);
    put_sighting(1'b1, 12'd3599, 9'd1);
    put_sighting(1'b0, 12'd0,    9'd0);

    // zero exit limit: first sighting goes straight outside
    configure(11'd0, 11'd2047, 11'd0);
    put_sighting(1'b1, 12'd100,  9'd0);
    put_sighting(1'b0, 12'd0,    9'd0);
    put_sighting(1'b1, 12'd2900, 9'd0);
    put_sighting(1'b1, 12'd2900, 9'd256);

    // half-turn exit, zero return, top speed bit masked off
    configure(11'd1800, 11'd0, 11'h7FF);
    put_sighting(1'b1, 12'd0,    9'd0);
    put_sighting(1'b1, 12'd1800, 9'd511);
    put_sighting(1'b1, 12'd0,    9'd0);
    put_sighting(1'b0, 12'd0,    9'd0);

    // exit limit beyond any gap
    configure(11'd2047, 11'd1000, 11'h400);
    put_sighting(1'b1, 12'd900,  9'd0);
    put_sighting(1'b1, 12'd2700, 9'd0);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) configure(11'd1200, 11'd800, 11'd768);
      else configure(pick_limit(), pick_limit(), 11'($urandom_range(0, 2047)));
      repeat (250) random_sighting();
    end

    item_if.valid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("boundary_line_escape_fsm verification clean");
    end else begin
      $display("boundary_line_escape_fsm verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    result_if.ready = 1'b0;
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0 || hold_results) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_results) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && result_if.valid));
      n_recv++;
      if (n_recv % 64 == 0) snk_steady = ($urandom_range(0, 3) == 0);
    end
  end

  // long result back-pressure while sightings keep coming
  initial begin
    wait (n_sent >= 400);
    @(negedge clk_i);
    hold_results = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_results = 1'b0;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/blef_pkg.sv
rtl/core/blef_if.sv
rtl/core/blef_cfg_regs.sv
rtl/core/blef_in_stage.sv
rtl/core/blef_core.sv
rtl/core/boundary_line_escape_fsm.sv
rtl/core/blef_checker.sv
tb/escape_move_checker.sv
tb/boundary_line_escape_fsm_tb.sv
